// ----- hdl/vfh_pkg.sv -----
// Package for the fractal value-noise height block.
// Holds the hash constants, fixed-point widths and configuration register codes.
// No dependencies.
package vfh_pkg;

    localparam int HEIGHT_W   = 24;
    localparam int NOISE_W    = 24;
    localparam int AMP_W      = 16;
    localparam int WEIGHT_W   = 16;
    localparam int CS_W       = 4;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;
    localparam int OCT_W      = 5;

    localparam logic [31:0] HASH_MUL_X   = 32'd374761393;
    localparam logic [31:0] HASH_MUL_Y   = 32'd668265263;
    localparam logic [31:0] HASH_MUL_MIX = 32'd1274126177;

    localparam logic [AMP_W-1:0]  AMP0       = 16'd32768;
    localparam logic [16:0]       WEIGHT_ONE = 17'h10000;
    localparam logic [17:0]       SMOOTH_K   = 18'd196608;

    localparam logic [CS_W-1:0]       RST_CELL_SHIFT   = 4'd5;
    localparam logic [CS_W-1:0]       RST_OCTAVE_COUNT = 4'd6;
    localparam logic [AMP_W-1:0]      RST_PERSISTENCE  = 16'd26214;
    localparam logic [AMP_W-1:0]      RST_HEIGHT_GAIN  = 16'd2560;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CELL_SHIFT   = 4'd0,
        CFG_OCTAVE_COUNT = 4'd1,
        CFG_PERSISTENCE  = 4'd2,
        CFG_HEIGHT_GAIN  = 4'd3
    } cfg_idx_t;

    // Final avalanche step of the corner hash, reduced to a Q0.24 fraction.
    function automatic logic [NOISE_W-1:0] hash_finish(input logic [31:0] m);
        logic [31:0] f;
        f = m ^ (m >> 16);
        return f[NOISE_W-1:0];
    endfunction

endpackage

// ----- hdl/vfh_octave_cell.sv -----
// One octave of the noise chain: hashes four lattice corners, blends them and
// adds the weighted octave value to the running sum. Five register stages.
// Depends on vfh_pkg.
module vfh_octave_cell #(
    parameter int COORD_BITS = 12,
    parameter int SUM_W      = 43,
    parameter int SHIFT      = 0
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  logic [vfh_pkg::CS_W-1:0]     cell_shift,
    input  logic [vfh_pkg::AMP_W-1:0]    amp,
    input  logic                         in_valid,
    input  logic [COORD_BITS-1:0]        in_x,
    input  logic [COORD_BITS-1:0]        in_y,
    input  logic [SUM_W-1:0]             in_acc,
    output logic                         out_valid,
    output logic [COORD_BITS-1:0]        out_x,
    output logic [COORD_BITS-1:0]        out_y,
    output logic [SUM_W-1:0]             out_acc
);
    import vfh_pkg::*;

    localparam int ST = 5;

    logic [ST-1:0]         v_reg;
    logic [COORD_BITS-1:0] x_reg   [ST];
    logic [COORD_BITS-1:0] y_reg   [ST];
    logic [SUM_W-1:0]      acc_reg [ST-1];

    // Stage 0 logic.
    logic [31:0] px, py, fmask, x0, y0, x1, y1, fx, fy;
    logic [15:0] tx, ty;
    logic [31:0] mx0_reg, mx1_reg, my0_reg, my1_reg, sqx_reg, sqy_reg;
    logic [15:0] tx_reg, ty_reg;

    // Stage 1 logic.
    logic [31:0] h00, h10, h01, h11;
    logic [31:0] m00_reg, m10_reg, m01_reg, m11_reg;
    logic [49:0] cubx, cuby;
    logic [WEIGHT_W-1:0] wx_reg, wy_reg, wy2_reg;

    // Stage 2 and 3 logic.
    logic [NOISE_W-1:0] n00, n10, n01, n11;
    logic [40:0] row0_sum, row1_sum, col_sum;
    logic [NOISE_W-1:0] row0_reg, row1_reg, val_reg;

    // Stage 4 logic.
    logic [NOISE_W+AMP_W-1:0] weighted;

    always_comb begin
        px    = 32'(in_x) << SHIFT;
        py    = 32'(in_y) << SHIFT;
        fmask = ~(32'hFFFF_FFFF << cell_shift);
        x0    = px >> cell_shift;
        y0    = py >> cell_shift;
        x1    = x0 + 32'd1;
        y1    = y0 + 32'd1;
        fx    = (px & fmask) << (5'd16 - 5'(cell_shift));
        fy    = (py & fmask) << (5'd16 - 5'(cell_shift));
        tx    = fx[15:0];
        ty    = fy[15:0];
    end

    always_comb begin
        h00  = mx0_reg + my0_reg;
        h10  = mx1_reg + my0_reg;
        h01  = mx0_reg + my1_reg;
        h11  = mx1_reg + my1_reg;
        cubx = 50'(sqx_reg) * 50'(SMOOTH_K - {1'b0, tx_reg, 1'b0});
        cuby = 50'(sqy_reg) * 50'(SMOOTH_K - {1'b0, ty_reg, 1'b0});
    end

    always_comb begin
        n00      = hash_finish(m00_reg);
        n10      = hash_finish(m10_reg);
        n01      = hash_finish(m01_reg);
        n11      = hash_finish(m11_reg);
        row0_sum = 41'(n00) * 41'(WEIGHT_ONE - 17'(wx_reg)) + 41'(n10) * 41'(wx_reg);
        row1_sum = 41'(n01) * 41'(WEIGHT_ONE - 17'(wx_reg)) + 41'(n11) * 41'(wx_reg);
        col_sum  = 41'(row0_reg) * 41'(WEIGHT_ONE - 17'(wy2_reg))
                 + 41'(row1_reg) * 41'(wy2_reg);
        weighted = (NOISE_W+AMP_W)'(val_reg) * (NOISE_W+AMP_W)'(amp);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[ST-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0]   <= in_x;
            y_reg[0]   <= in_y;
            acc_reg[0] <= in_acc;
            for (int i = 1; i < ST; i++) begin
                x_reg[i]   <= x_reg[i-1];
                y_reg[i]   <= y_reg[i-1];
            end
            for (int i = 1; i < ST-1; i++) begin
                acc_reg[i] <= acc_reg[i-1];
            end
            mx0_reg  <= x0 * HASH_MUL_X;
            mx1_reg  <= x1 * HASH_MUL_X;
            my0_reg  <= y0 * HASH_MUL_Y;
            my1_reg  <= y1 * HASH_MUL_Y;
            sqx_reg  <= 32'(tx) * 32'(tx);
            sqy_reg  <= 32'(ty) * 32'(ty);
            tx_reg   <= tx;
            ty_reg   <= ty;
            m00_reg  <= (h00 ^ (h00 >> 13)) * HASH_MUL_MIX;
            m10_reg  <= (h10 ^ (h10 >> 13)) * HASH_MUL_MIX;
            m01_reg  <= (h01 ^ (h01 >> 13)) * HASH_MUL_MIX;
            m11_reg  <= (h11 ^ (h11 >> 13)) * HASH_MUL_MIX;
            wx_reg   <= cubx[47:32];
            wy_reg   <= cuby[47:32];
            row0_reg <= row0_sum[39:16];
            row1_reg <= row1_sum[39:16];
            wy2_reg  <= wy_reg;
            val_reg  <= col_sum[39:16];
        end
    end

    // The last stage folds the weighted octave into the sum on its way out.
    logic [SUM_W-1:0] acc_out_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            acc_out_reg <= acc_reg[ST-2] + SUM_W'(weighted);
        end
    end

    assign out_valid = v_reg[ST-1];
    assign out_x     = x_reg[ST-1];
    assign out_y     = y_reg[ST-1];
    assign out_acc   = acc_out_reg;

endmodule

// ----- hdl/vfh_div_cell.sv -----
// One step of the pipelined restoring divider: decides one quotient bit.
// Depends on vfh_pkg for the quotient width.
module vfh_div_cell #(
    parameter int SUM_W  = 43,
    parameter int NORM_W = 19,
    parameter int BIT    = 0
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic [NORM_W-1:0]           norm,
    input  logic                        in_valid,
    input  logic [SUM_W-1:0]            in_rem,
    input  logic [vfh_pkg::NOISE_W-1:0] in_quo,
    output logic                        out_valid,
    output logic [SUM_W-1:0]            out_rem,
    output logic [vfh_pkg::NOISE_W-1:0] out_quo
);
    import vfh_pkg::*;

    logic                 v_reg;
    logic [SUM_W-1:0]     rem_reg;
    logic [NOISE_W-1:0]   quo_reg;
    logic [SUM_W-1:0]     sub;
    logic                 ge;

    assign sub = SUM_W'(norm) << BIT;
    assign ge  = (in_rem >= sub);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (en) begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg <= ge ? (in_rem - sub) : in_rem;
            quo_reg <= in_quo | (NOISE_W'(ge) << BIT);
        end
    end

    assign out_valid = v_reg;
    assign out_rem   = rem_reg;
    assign out_quo   = quo_reg;

endmodule

// ----- hdl/value_noise_fbm_height.sv -----
// Top level of the fractal value-noise height generator.
// Instantiates the octave cell chain and the divider cell chain; uses vfh_pkg.
//
//   channel  ports                              moves
//   s_       s_valid/s_ready, s_x_coord/y       grid point request
//   m_       m_valid/m_ready, m_height          height result
//   cfg_     cfg_valid/cfg_ready, index/data    register write
//
// One request per clock while s_ready is high. The path runs through five stages per
// octave cell, one per quotient bit of the normalizing divider, one for the gain.
// After reset and after every register write the amplitude table is rebuilt
// one octave at a time with one multiplier; s_ready is low meanwhile.
// The whole pipeline holds while a result waits on m_ready.
module value_noise_fbm_height #(
    parameter int MAX_OCTAVES = 8,
    parameter int COORD_BITS  = 12
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [COORD_BITS-1:0]          s_x_coord,
    input  logic [COORD_BITS-1:0]          s_y_coord,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [vfh_pkg::HEIGHT_W-1:0]   m_height,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [vfh_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [vfh_pkg::CFG_DATA_W-1:0] cfg_data
);
    import vfh_pkg::*;

    localparam int LOG_OCT = $clog2(MAX_OCTAVES);
    localparam int SUM_W   = NOISE_W + AMP_W + LOG_OCT;
    localparam int NORM_W  = AMP_W + LOG_OCT;
    localparam int IDX_W   = (MAX_OCTAVES > 1) ? LOG_OCT : 1;

    // Configuration and amplitude table.
    logic [CS_W-1:0]   cell_shift_reg;
    logic [CS_W-1:0]   octave_count_reg;
    logic [AMP_W-1:0]  persistence_reg;
    logic [AMP_W-1:0]  height_gain_reg;
    logic              busy_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [AMP_W-1:0]  amp_cur_reg;
    logic [AMP_W-1:0]  amp_cur_next;
    logic [NORM_W-1:0] norm_reg;
    logic [AMP_W-1:0]  amp_reg [MAX_OCTAVES];
    logic [OCT_W-1:0]  oct_eff;
    logic [AMP_W-1:0]  amp_use;
    logic [2*AMP_W-1:0] amp_prod;

    always_comb begin
        if (octave_count_reg == '0) begin
            oct_eff = OCT_W'(1);
        end else if (OCT_W'(octave_count_reg) > OCT_W'(MAX_OCTAVES)) begin
            oct_eff = OCT_W'(MAX_OCTAVES);
        end else begin
            oct_eff = OCT_W'(octave_count_reg);
        end
        // Octaves past the count get zero weight, so every cell can always run.
        amp_use      = (OCT_W'(idx_reg) < oct_eff) ? amp_cur_reg : '0;
        amp_prod     = (2*AMP_W)'(amp_cur_reg) * (2*AMP_W)'(persistence_reg);
        amp_cur_next = amp_prod[2*AMP_W-1:AMP_W];
    end

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_shift_reg   <= RST_CELL_SHIFT;
            octave_count_reg <= RST_OCTAVE_COUNT;
            persistence_reg  <= RST_PERSISTENCE;
            height_gain_reg  <= RST_HEIGHT_GAIN;
            busy_reg         <= 1'b1;
            idx_reg          <= '0;
            amp_cur_reg      <= AMP0;
            norm_reg         <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_CELL_SHIFT:   cell_shift_reg   <= cfg_data[CS_W-1:0];
                CFG_OCTAVE_COUNT: octave_count_reg <= cfg_data[CS_W-1:0];
                CFG_PERSISTENCE:  persistence_reg  <= cfg_data;
                CFG_HEIGHT_GAIN:  height_gain_reg  <= cfg_data;
                default: ;
            endcase
            busy_reg    <= 1'b1;
            idx_reg     <= '0;
            amp_cur_reg <= AMP0;
            norm_reg    <= '0;
        end else if (busy_reg) begin
            norm_reg    <= norm_reg + NORM_W'(amp_use);
            amp_cur_reg <= amp_cur_next;
            idx_reg     <= idx_reg + IDX_W'(1);
            if (idx_reg == IDX_W'(MAX_OCTAVES - 1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (busy_reg && !cfg_valid) begin
            amp_reg[idx_reg] <= amp_use;
        end
    end

    // Pipeline control.
    logic m_valid_reg;
    logic [HEIGHT_W-1:0] m_height_reg;
    logic adv;

    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv && !busy_reg;

    // Octave chain.
    logic                  oc_v [MAX_OCTAVES+1];
    logic [COORD_BITS-1:0] oc_x [MAX_OCTAVES+1];
    logic [COORD_BITS-1:0] oc_y [MAX_OCTAVES+1];
    logic [SUM_W-1:0]      oc_a [MAX_OCTAVES+1];

    assign oc_v[0] = s_valid && s_ready;
    assign oc_x[0] = s_x_coord;
    assign oc_y[0] = s_y_coord;
    assign oc_a[0] = '0;

    for (genvar k = 0; k < MAX_OCTAVES; k++) begin : g_oct
        vfh_octave_cell #(
            .COORD_BITS (COORD_BITS),
            .SUM_W      (SUM_W),
            .SHIFT      (k)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .en         (adv),
            .cell_shift (cell_shift_reg),
            .amp        (amp_reg[k]),
            .in_valid   (oc_v[k]),
            .in_x       (oc_x[k]),
            .in_y       (oc_y[k]),
            .in_acc     (oc_a[k]),
            .out_valid  (oc_v[k+1]),
            .out_x      (oc_x[k+1]),
            .out_y      (oc_y[k+1]),
            .out_acc    (oc_a[k+1])
        );
    end

    // Normalizing divider, most significant quotient bit first.
    logic               dv_v [NOISE_W+1];
    logic [SUM_W-1:0]   dv_r [NOISE_W+1];
    logic [NOISE_W-1:0] dv_q [NOISE_W+1];

    assign dv_v[0] = oc_v[MAX_OCTAVES];
    assign dv_r[0] = oc_a[MAX_OCTAVES];
    assign dv_q[0] = '0;

    for (genvar i = 0; i < NOISE_W; i++) begin : g_div
        vfh_div_cell #(
            .SUM_W  (SUM_W),
            .NORM_W (NORM_W),
            .BIT    (NOISE_W - 1 - i)
        ) u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (adv),
            .norm      (norm_reg),
            .in_valid  (dv_v[i]),
            .in_rem    (dv_r[i]),
            .in_quo    (dv_q[i]),
            .out_valid (dv_v[i+1]),
            .out_rem   (dv_r[i+1]),
            .out_quo   (dv_q[i+1])
        );
    end

    // Gain stage. The Q8.16 product of a Q0.24 value and a Q8.8 gain always
    // fits 24 bits, so the saturation limit is met by construction.
    logic [NOISE_W+AMP_W-1:0] gain_prod;
    assign gain_prod = (NOISE_W+AMP_W)'(dv_q[NOISE_W]) * (NOISE_W+AMP_W)'(height_gain_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= dv_v[NOISE_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_height_reg <= gain_prod[NOISE_W+AMP_W-1:AMP_W];
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_height = m_height_reg;

endmodule

// ----- sim/tb.sv -----
// Testbench for the fractal value-noise height block.
// Predicts each height in SystemVerilog and checks results in order; uses vfh_pkg.
// Depends on hdl/vfh_pkg.sv and hdl/value_noise_fbm_height.sv.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import vfh_pkg::*;

    localparam int MAX_OCT     = 8;
    localparam int CB          = 12;
    localparam int LATENCY     = 5 * MAX_OCT + 25;
    localparam int STALL_LIM   = 20000;
    localparam int RAND_ITEMS  = 1900;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic [CB-1:0] x;
        logic [CB-1:0] y;
    } point_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [CB-1:0]         s_x_coord = '0;
    logic [CB-1:0]         s_y_coord = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [HEIGHT_W-1:0]   m_height;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    value_noise_fbm_height #(.MAX_OCTAVES(MAX_OCT), .COORD_BITS(CB)) uut (.*);

    always #6 aclk = ~aclk;

    // Shadow copy of the configuration registers.
    logic [3:0]  sh_cell_shift = RST_CELL_SHIFT;
    logic [3:0]  sh_octaves    = RST_OCTAVE_COUNT;
    logic [15:0] sh_persist    = RST_PERSISTENCE;
    logic [15:0] sh_gain       = RST_HEIGHT_GAIN;

    point_t              pending_points[$];
    logic [HEIGHT_W-1:0] expected_heights[$];
    int  mismatches = 0;
    int  idle_cycles = 0;
    bit  hold_sink = 1'b0;
    bit  hold_done = 1'b0;
    bit  feeding = 1'b0;
    bit  timed_out = 1'b0;

    function automatic logic [23:0] lattice_noise(logic [31:0] lx, logic [31:0] ly);
        logic [31:0] h;
        h = lx * 32'd374761393 + ly * 32'd668265263;
        h = (h ^ (h >> 13)) * 32'd1274126177;
        h = h ^ (h >> 16);
        return h[23:0];
    endfunction

    function automatic logic [63:0] smooth(logic [63:0] t);
        return (t * t * (64'd196608 - 64'd2 * t)) >> 32;
    endfunction

    function automatic logic [63:0] mix(logic [63:0] a, logic [63:0] b, logic [63:0] w);
        return (a * (64'd65536 - w) + b * w) >> 16;
    endfunction

    function automatic logic [HEIGHT_W-1:0] predict_height(point_t p);
        logic [63:0] px, py, fmask, tx, ty, wx, wy, r0, r1, amp, norm, acc, n, h;
        logic [31:0] x0, y0;
        int oct;
        amp = 64'd32768;
        norm = 0;
        acc = 0;
        oct = sh_octaves;
        if (oct < 1) oct = 1;
        if (oct > MAX_OCT) oct = MAX_OCT;
        fmask = (64'd1 << sh_cell_shift) - 1;
        for (int k = 0; k < oct; k++) begin
            px = 64'(p.x) << k;
            py = 64'(p.y) << k;
            x0 = 32'(px >> sh_cell_shift);
            y0 = 32'(py >> sh_cell_shift);
            tx = (px & fmask) << (16 - sh_cell_shift);
            ty = (py & fmask) << (16 - sh_cell_shift);
            wx = smooth(tx);
            wy = smooth(ty);
            r0 = mix(lattice_noise(x0, y0), lattice_noise(x0 + 1, y0), wx);
            r1 = mix(lattice_noise(x0, y0 + 1), lattice_noise(x0 + 1, y0 + 1), wx);
            acc += amp * mix(r0, r1, wy);
            norm += amp;
            amp = (amp * sh_persist) >> 16;
        end
        n = acc / norm;
        h = (n * sh_gain) >> 16;
        if (h > 64'hFFFFFF) h = 64'hFFFFFF;
        return h[23:0];
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // Accept flag captured at the rising edge so the driver sees a stable value.
    logic s_ready_seen = 1'b0;
    always @(posedge aclk) s_ready_seen <= s_valid && s_ready;

    // Driver: offers queued points with random gaps.
    int src_gap = 0;
    always @(negedge aclk) begin
        if (!s_valid || s_ready_seen) begin
            if (src_gap > 0) begin
                src_gap <= src_gap - 1;
                s_valid <= 1'b0;
            end else if (feeding && pending_points.size() > 0) begin
                s_x_coord <= pending_points[0].x;
                s_y_coord <= pending_points[0].y;
                s_valid <= 1'b1;
                expected_heights.push_back(predict_height(pending_points[0]));
                pending_points.pop_front();
                src_gap <= pick_gap();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stall, or a long hold-off counted here when requested.
    int sink_gap = 0;
    int hold_count = 0;
    always @(negedge aclk) begin
        if (hold_sink && !hold_done) begin
            m_ready <= 1'b0;
            hold_count <= hold_count + 1;
            if (hold_count >= HOLD_CYCLES - 1) hold_done <= 1'b1;
        end else if (sink_gap > 0) begin
            sink_gap <= sink_gap - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            sink_gap <= pick_gap();
        end
    end

    // Monitor and watchdog.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (m_valid && m_ready) begin
                if (expected_heights.size() == 0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10) $display("Unexpected height %h", m_height);
                end else begin
                    if (m_height !== expected_heights[0]) begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display("Height mismatch: expected %h, got %h",
                                     expected_heights[0], m_height);
                    end
                    expected_heights.pop_front();
                end
            end
        end
    end

    task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
        @(negedge aclk);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_CELL_SHIFT:   sh_cell_shift = val[3:0];
            CFG_OCTAVE_COUNT: sh_octaves = val[3:0];
            CFG_PERSISTENCE:  sh_persist = val;
            CFG_HEIGHT_GAIN:  sh_gain = val;
            default: ;
        endcase
    endtask

    task automatic drain();
        wait (pending_points.size() == 0 && !s_valid && expected_heights.size() == 0);
        feeding = 1'b0;
        repeat (LATENCY + 5) @(posedge aclk);
    endtask

    task automatic run_points(int count);
        point_t p;
        for (int i = 0; i < count; i++) begin
            p.x = CB'($urandom);
            p.y = CB'($urandom);
            pending_points.push_back(p);
        end
        feeding = 1'b1;
        drain();
    endtask

    task automatic set_all(logic [15:0] cs, logic [15:0] oc, logic [15:0] ps, logic [15:0] g);
        write_reg(CFG_CELL_SHIFT, cs);
        write_reg(CFG_OCTAVE_COUNT, oc);
        write_reg(CFG_PERSISTENCE, ps);
        write_reg(CFG_HEIGHT_GAIN, g);
    endtask

    initial begin
        forever begin
            @(posedge aclk);
            if (idle_cycles >= STALL_LIM && !timed_out) begin
                timed_out = 1'b1;
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin
        point_t p;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: coordinate extremes and alternating bit patterns under reset settings.
        for (int i = 0; i < 4; i++) begin
            p.x = (i[0]) ? '1 : '0;
            p.y = (i[1]) ? '1 : '0;
            pending_points.push_back(p);
        end
        p.x = 12'hAAA; p.y = 12'h555; pending_points.push_back(p);
        p.x = 12'h555; p.y = 12'hAAA; pending_points.push_back(p);
        feeding = 1'b1;
        drain();

        // Zero octaves, zero cell shift, zero persistence, full gain.
        set_all(16'd0, 16'd0, 16'd0, 16'hFFFF);
        run_points(6);
        // Cell shift and octave count above their nominal ranges.
        set_all(16'd15, 16'd15, 16'hFFFF, 16'hFFFF);
        run_points(6);
        set_all(16'd8, 16'd8, 16'hFFFF, 16'd0);
        run_points(4);
        // Unknown register index must be ignored.
        write_reg(cfg_idx_t'(4'd9), 16'h1234);
        write_reg(cfg_idx_t'(4'd15), 16'hFFFF);
        run_points(3);

        // Long receiver hold-off while the sender keeps offering.
        set_all(16'd5, 16'd6, 16'd26214, 16'd2560);
        hold_sink = 1'b1;
        for (int i = 0; i < 200; i++) begin
            p.x = CB'($urandom); p.y = CB'($urandom);
            pending_points.push_back(p);
        end
        feeding = 1'b1;
        wait (hold_done);
        hold_sink = 1'b0;
        drain();

        for (int phase = 0; phase < 8; phase++) begin
            set_all(16'($urandom_range(0, 15)), 16'($urandom_range(0, 15)),
                    16'($urandom), 16'($urandom));
            run_points(RAND_ITEMS / 8 - 25);
        end

        if (mismatches == 0 && expected_heights.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
